FILE: rtl/core/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI stream decoder package
// Codes, constants and the result record shared by the decoder core.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Byte values with a fixed meaning
    localparam logic [7:0] BYTE_ACTIVE_SENSE = 8'hFE;
    localparam logic [7:0] BYTE_SYSTEM_BASE  = 8'd240;
    localparam logic [7:0] BYTE_SYSEX        = 8'd240;
    localparam logic [7:0] BYTE_SONG_POS     = 8'd242;
    localparam logic [7:0] BYTE_SONG_SEL     = 8'd243;
    localparam logic [7:0] BYTE_TUNE         = 8'd246;
    localparam logic [7:0] BYTE_EOX          = 8'd247;
    localparam logic [7:0] BYTE_CLOCK        = 8'd248;
    localparam logic [7:0] BYTE_START        = 8'd250;
    localparam logic [7:0] BYTE_CONTINUE     = 8'd251;
    localparam logic [7:0] BYTE_STOP         = 8'd252;
    localparam logic [7:0] BYTE_RESET        = 8'd255;

    // byte_kind codes
    localparam logic [2:0] BK_STATUS       = 3'd0;
    localparam logic [2:0] BK_DATA_SAME    = 3'd1;
    localparam logic [2:0] BK_DATA_NEW_ROW = 3'd2;
    localparam logic [2:0] BK_SENSE_FIRST  = 3'd3;
    localparam logic [2:0] BK_SENSE_REPEAT = 3'd4;

    // status_code values for system bytes
    localparam logic [4:0] SC_SYSEX     = 5'd7;
    localparam logic [4:0] SC_SONG_POS  = 5'd8;
    localparam logic [4:0] SC_SONG_SEL  = 5'd9;
    localparam logic [4:0] SC_TUNE      = 5'd10;
    localparam logic [4:0] SC_EOX       = 5'd11;
    localparam logic [4:0] SC_CLOCK     = 5'd12;
    localparam logic [4:0] SC_START     = 5'd13;
    localparam logic [4:0] SC_CONTINUE  = 5'd14;
    localparam logic [4:0] SC_STOP      = 5'd15;
    localparam logic [4:0] SC_RESET     = 5'd16;
    localparam logic [4:0] SC_UNDEFINED = 5'd17;

    // Message kinds (running status)
    localparam logic [2:0] MK_UNKNOWN   = 3'd0;
    localparam logic [2:0] MK_NOTE_PAIR = 3'd1;
    localparam logic [2:0] MK_KEY_PRESS = 3'd2;
    localparam logic [2:0] MK_CONTROL   = 3'd3;
    localparam logic [2:0] MK_PLAIN     = 3'd4;
    localparam logic [2:0] MK_BEND      = 3'd5;
    localparam logic [2:0] MK_SONG_POS  = 3'd6;
    localparam logic [2:0] MK_CHAN_PRES = 3'd7;

    // data_role codes
    localparam logic [3:0] DR_UNKNOWN    = 4'd0;
    localparam logic [3:0] DR_NOTE       = 4'd1;
    localparam logic [3:0] DR_VELOCITY   = 4'd2;
    localparam logic [3:0] DR_VALUE      = 4'd3;
    localparam logic [3:0] DR_CONTROLLER = 4'd4;
    localparam logic [3:0] DR_PLAIN      = 4'd5;
    localparam logic [3:0] DR_BEND_LOW   = 4'd6;
    localparam logic [3:0] DR_BEND_FULL  = 4'd7;
    localparam logic [3:0] DR_SPP_LOW    = 4'd8;
    localparam logic [3:0] DR_SPP_FULL   = 4'd9;

    localparam logic [13:0] BEND_CENTRE = 14'd8192;

    // Result record, first member in the highest bits of the struct
    typedef struct packed {
        logic        [4:0]  song_clock;
        logic        [2:0]  song_beat;
        logic        [10:0] song_measure;
        logic signed [13:0] bend_value;
        logic               controller_lsb;
        logic signed [4:0]  note_octave;
        logic        [3:0]  note_pitch;
        logic        [3:0]  data_role;
        logic        [4:0]  channel_number;
        logic        [4:0]  status_code;
        logic        [2:0]  byte_kind;
        logic        [15:0] byte_index;
    } result_t;

    // Running status for channel status bytes, indexed by bits 6:4
    function automatic logic [2:0] kind_of_status(input logic [2:0] t);
        logic [2:0] k;
        case (t)
            3'd0:    k = MK_NOTE_PAIR;
            3'd1:    k = MK_NOTE_PAIR;
            3'd2:    k = MK_KEY_PRESS;
            3'd3:    k = MK_CONTROL;
            3'd4:    k = MK_PLAIN;
            3'd5:    k = MK_CHAN_PRES;
            3'd6:    k = MK_BEND;
            default: k = MK_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/core/midi_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI stream decoder core
// Decodes one MIDI byte per transfer into status, data role and values.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result in the following cycle. The decode is
// a single pass of short logic from the input byte and the running-status
// registers into the output register, so a byte is taken every cycle for as
// long as the result side takes transfers; s_tready drops only while a
// result waits in the output register and m_tready is low. Active sensing
// is reported but not counted in byte_index.
module midi_stream_decoder_core
    import msd_pkg::*;
#(
    parameter int ROW_BYTES = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] midi_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] byte_index, [18:16] byte_kind, [23:19] status_code,
    // [28:24] channel_number, [32:29] data_role, [36:33] note_pitch,
    // [41:37] note_octave, [42] controller_lsb, [56:43] bend_value,
    // [67:57] song_measure, [70:68] song_beat, [75:71] song_clock, [79:76] 0
    output logic [79:0] m_tdata
);

    localparam logic [2:0] ROW_LIMIT = 3'(ROW_BYTES);

    logic [2:0]  kind_reg,    kind_next;
    logic        second_reg,  second_next;
    logic [6:0]  low_reg,     low_next;
    logic [15:0] counter_reg, counter_next;
    logic [1:0]  row_reg,     row_next;
    logic        sense_reg,   sense_next;

    result_t     res_reg, res_next;
    logic        valid_reg;

    logic        accept;
    logic [6:0]  data7;
    logic [8:0]  div_prod;
    logic [3:0]  note_quo;
    logic [6:0]  note_rem;
    logic [13:0] full;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg};

    // note / 12 as (note / 4) / 3, the latter by reciprocal 11/32 (exact below 32)
    assign data7    = s_tdata[6:0];
    assign div_prod = 9'(s_tdata[6:2]) * 9'd11;
    assign note_quo = div_prod[8:5];
    assign note_rem = data7 - 7'({note_quo, 3'b000}) - 7'({note_quo, 2'b00});
    assign full     = {data7, low_reg};

    always_comb
    begin
        res_next     = '0;
        kind_next    = kind_reg;
        second_next  = second_reg;
        low_next     = low_reg;
        counter_next = counter_reg;
        row_next     = row_reg;
        sense_next   = sense_reg;

        if (s_tdata == BYTE_ACTIVE_SENSE)
        begin
            res_next.byte_index = counter_reg;
            res_next.byte_kind  = sense_reg ? BK_SENSE_REPEAT : BK_SENSE_FIRST;
            sense_next          = 1'b1;
            row_next            = 2'd0;
        end
        else
        begin
            counter_next        = counter_reg + 16'd1;
            res_next.byte_index = counter_next;

            if (s_tdata[7])
            begin
                row_next           = 2'd0;
                res_next.byte_kind = BK_STATUS;
                if (s_tdata < BYTE_SYSTEM_BASE)
                begin
                    res_next.status_code    = 5'(s_tdata[6:4]);
                    res_next.channel_number = 5'(s_tdata[3:0]) + 5'd1;
                    kind_next               = kind_of_status(s_tdata[6:4]);
                    second_next             = 1'b0;
                end
                else
                begin
                    case (s_tdata)
                        BYTE_SYSEX:
                        begin
                            res_next.status_code = SC_SYSEX;
                            kind_next            = MK_PLAIN;
                            second_next          = 1'b0;
                        end
                        BYTE_SONG_POS:
                        begin
                            res_next.status_code = SC_SONG_POS;
                            kind_next            = MK_SONG_POS;
                            second_next          = 1'b0;
                        end
                        BYTE_SONG_SEL:
                        begin
                            res_next.status_code = SC_SONG_SEL;
                            kind_next            = MK_PLAIN;
                            second_next          = 1'b0;
                        end
                        BYTE_TUNE:
                        begin
                            res_next.status_code = SC_TUNE;
                            kind_next            = MK_UNKNOWN;
                        end
                        BYTE_EOX:
                        begin
                            res_next.status_code = SC_EOX;
                            kind_next            = MK_UNKNOWN;
                        end
                        // real-time bytes hold running status
                        BYTE_CLOCK:    res_next.status_code = SC_CLOCK;
                        BYTE_START:    res_next.status_code = SC_START;
                        BYTE_CONTINUE: res_next.status_code = SC_CONTINUE;
                        BYTE_STOP:     res_next.status_code = SC_STOP;
                        BYTE_RESET:    res_next.status_code = SC_RESET;
                        default:
                        begin
                            res_next.status_code = SC_UNDEFINED;
                            kind_next            = MK_UNKNOWN;
                        end
                    endcase
                end
            end
            else
            begin
                if (!second_reg)
                begin
                    case (kind_reg)
                        MK_NOTE_PAIR, MK_KEY_PRESS:
                        begin
                            res_next.data_role   = DR_NOTE;
                            res_next.note_pitch  = note_rem[3:0];
                            res_next.note_octave = signed'(5'(note_quo) - 5'd1);
                            second_next          = 1'b1;
                        end
                        MK_CONTROL:
                        begin
                            res_next.data_role      = DR_CONTROLLER;
                            res_next.controller_lsb = (data7[6:5] == 2'b01);
                            second_next             = 1'b1;
                        end
                        MK_PLAIN:     res_next.data_role = DR_PLAIN;
                        MK_BEND:
                        begin
                            res_next.data_role = DR_BEND_LOW;
                            low_next           = data7;
                            second_next        = 1'b1;
                        end
                        MK_SONG_POS:
                        begin
                            res_next.data_role = DR_SPP_LOW;
                            low_next           = data7;
                            second_next        = 1'b1;
                        end
                        MK_CHAN_PRES: res_next.data_role = DR_VALUE;
                        default:      res_next.data_role = DR_UNKNOWN;
                    endcase
                end
                else
                begin
                    case (kind_reg)
                        MK_NOTE_PAIR:
                        begin
                            res_next.data_role = DR_VELOCITY;
                            second_next        = 1'b0;
                        end
                        MK_KEY_PRESS, MK_CONTROL, MK_CHAN_PRES:
                        begin
                            res_next.data_role = DR_VALUE;
                            second_next        = 1'b0;
                        end
                        MK_PLAIN:     res_next.data_role = DR_PLAIN;
                        MK_BEND:
                        begin
                            res_next.data_role  = DR_BEND_FULL;
                            res_next.bend_value = signed'(full - BEND_CENTRE);
                            second_next         = 1'b0;
                        end
                        MK_SONG_POS:
                        begin
                            res_next.data_role    = DR_SPP_FULL;
                            res_next.song_measure = 11'(full[13:4]) + 11'd1;
                            res_next.song_beat    = 3'(full[3:2]) + 3'd1;
                            res_next.song_clock   = 5'(full[1:0]) * 5'd6 + 5'd1;
                            second_next           = 1'b0;
                        end
                        default:      res_next.data_role = DR_UNKNOWN;
                    endcase
                end

                // start a new display row once the row is full
                if (3'(row_reg) + 3'd1 > ROW_LIMIT)
                begin
                    row_next           = 2'd1;
                    res_next.byte_kind = BK_DATA_NEW_ROW;
                end
                else
                begin
                    row_next           = row_reg + 2'd1;
                    res_next.byte_kind = BK_DATA_SAME;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= MK_UNKNOWN;
            second_reg  <= 1'b0;
            low_reg     <= 7'd0;
            counter_reg <= 16'd0;
            row_reg     <= 2'd0;
            sense_reg   <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                kind_reg    <= kind_next;
                second_reg  <= second_next;
                low_reg     <= low_next;
                counter_reg <= counter_next;
                row_reg     <= row_next;
                sense_reg   <= sense_next;
                valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the downstream transfer completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        3'(row_reg) <= ROW_LIMIT)
        else $error("row count above row length");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tdata != BYTE_ACTIVE_SENSE)
        |=> counter_reg == $past(counter_reg) + 16'd1)
        else $error("byte counter did not advance");

    a_sense_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tdata == BYTE_ACTIVE_SENSE)
        |=> sense_reg && counter_reg == $past(counter_reg) && row_reg == 2'd0)
        else $error("active sense disturbed the count");

    a_status_role: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.byte_kind == BK_STATUS)
        |-> res_reg.data_role == DR_UNKNOWN && res_reg.status_code <= SC_UNDEFINED)
        else $error("status result carries a data role");

    a_result_index: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tdata != BYTE_ACTIVE_SENSE)
        |=> valid_reg && res_reg.byte_index == counter_reg)
        else $error("result index differs from counter");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI stream decoder core testbench
// Drives raw MIDI bytes into the decoder and checks every decoded result
// against a behavioural predictor of the running-status decoder, or against
// the fixed result that a directed byte gives. A short table of directed
// bytes comes first, then mostly well-formed messages with random content,
// real-time interjections and noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import msd_pkg::*;

    localparam int ROW_BYTES      = 2;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int REPORT_LIMIT   = 10;

    // status_code values of channel messages, and the zero of unused fields
    localparam logic [4:0] SC_NONE       = 5'd0;
    localparam logic [4:0] SC_NOTE_OFF   = 5'd0;
    localparam logic [4:0] SC_PITCH_BEND = 5'd6;
    localparam logic [4:0] CH_NONE       = 5'd0;

    typedef struct {
        logic [7:0] midi_byte;
        bit         has_expect;
        result_t    want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    // predictor state
    logic [2:0]  run_kind;
    bit          second_pending;
    logic [6:0]  held_low;
    logic [15:0] byte_count;
    logic [1:0]  row_fill;
    bit          sense_reported;

    result_t     expected_results[$];
    dir_row_t    dir_rows[$];
    int          mismatches  = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          no_idle     = 1'b0;
    result_t     want_res;
    result_t     got_res;

    midi_stream_decoder_core #(
        .ROW_BYTES (ROW_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic result_t fixed_result(input logic [15:0] idx, input logic [2:0] kind,
                                             input logic [4:0] code, input logic [4:0] chan,
                                             input logic [3:0] role);
        result_t r;
        r = '0;
        r.byte_index     = idx;
        r.byte_kind      = kind;
        r.status_code    = code;
        r.channel_number = chan;
        r.data_role      = role;
        return r;
    endfunction

    // Decode one byte and advance the running-status state
    function automatic result_t decode_midi_byte(input logic [7:0] b);
        result_t     r;
        logic [13:0] full;
        int          oct;
        r = '0;
        if (b == BYTE_ACTIVE_SENSE)
        begin
            r.byte_index   = byte_count;
            r.byte_kind    = sense_reported ? BK_SENSE_REPEAT : BK_SENSE_FIRST;
            sense_reported = 1'b1;
            row_fill       = 2'd0;
            return r;
        end
        byte_count   = byte_count + 16'd1;
        r.byte_index = byte_count;
        if (b[7])
        begin
            row_fill    = 2'd0;
            r.byte_kind = BK_STATUS;
            if (b < BYTE_SYSTEM_BASE)
            begin
                r.status_code    = {2'b00, b[6:4]};
                r.channel_number = 5'(b[3:0]) + 5'd1;
                second_pending   = 1'b0;
                case (b[6:4])
                    3'd0, 3'd1: run_kind = MK_NOTE_PAIR;
                    3'd2:       run_kind = MK_KEY_PRESS;
                    3'd3:       run_kind = MK_CONTROL;
                    3'd4:       run_kind = MK_PLAIN;
                    3'd5:       run_kind = MK_CHAN_PRES;
                    3'd6:       run_kind = MK_BEND;
                    default:    run_kind = MK_UNKNOWN;
                endcase
            end
            else
            begin
                case (b)
                    BYTE_SYSEX:
                    begin
                        r.status_code = SC_SYSEX;
                        run_kind = MK_PLAIN;
                        second_pending = 1'b0;
                    end
                    BYTE_SONG_POS:
                    begin
                        r.status_code = SC_SONG_POS;
                        run_kind = MK_SONG_POS;
                        second_pending = 1'b0;
                    end
                    BYTE_SONG_SEL:
                    begin
                        r.status_code = SC_SONG_SEL;
                        run_kind = MK_PLAIN;
                        second_pending = 1'b0;
                    end
                    BYTE_TUNE:
                    begin
                        r.status_code = SC_TUNE;
                        run_kind = MK_UNKNOWN;
                    end
                    BYTE_EOX:
                    begin
                        r.status_code = SC_EOX;
                        run_kind = MK_UNKNOWN;
                    end
                    BYTE_CLOCK:    r.status_code = SC_CLOCK;
                    BYTE_START:    r.status_code = SC_START;
                    BYTE_CONTINUE: r.status_code = SC_CONTINUE;
                    BYTE_STOP:     r.status_code = SC_STOP;
                    BYTE_RESET:    r.status_code = SC_RESET;
                    default:
                    begin
                        r.status_code = SC_UNDEFINED;
                        run_kind = MK_UNKNOWN;
                    end
                endcase
            end
            return r;
        end
        full = {b[6:0], held_low};
        if (!second_pending)
        begin
            case (run_kind)
                MK_NOTE_PAIR, MK_KEY_PRESS:
                begin
                    oct = int'(b) / 12 - 1;
                    r.data_role    = DR_NOTE;
                    r.note_pitch   = 4'(b % 8'd12);
                    r.note_octave  = oct[4:0];
                    second_pending = 1'b1;
                end
                MK_CONTROL:
                begin
                    r.data_role      = DR_CONTROLLER;
                    r.controller_lsb = (b >= 8'd32 && b <= 8'd63);
                    second_pending   = 1'b1;
                end
                MK_PLAIN: r.data_role = DR_PLAIN;
                MK_BEND, MK_SONG_POS:
                begin
                    r.data_role    = (run_kind == MK_BEND) ? DR_BEND_LOW : DR_SPP_LOW;
                    held_low       = b[6:0];
                    second_pending = 1'b1;
                end
                MK_CHAN_PRES: r.data_role = DR_VALUE;
                default:      r.data_role = DR_UNKNOWN;
            endcase
        end
        else
        begin
            case (run_kind)
                MK_NOTE_PAIR:
                begin
                    r.data_role    = DR_VELOCITY;
                    second_pending = 1'b0;
                end
                MK_KEY_PRESS, MK_CONTROL, MK_CHAN_PRES:
                begin
                    r.data_role    = DR_VALUE;
                    second_pending = 1'b0;
                end
                MK_PLAIN: r.data_role = DR_PLAIN;
                MK_BEND:
                begin
                    r.data_role    = DR_BEND_FULL;
                    r.bend_value   = full - BEND_CENTRE;
                    second_pending = 1'b0;
                end
                MK_SONG_POS:
                begin
                    r.data_role    = DR_SPP_FULL;
                    r.song_measure = 11'(full[13:4]) + 11'd1;
                    r.song_beat    = 3'(full[3:2]) + 3'd1;
                    r.song_clock   = 5'(full[1:0]) * 5'd6 + 5'd1;
                    second_pending = 1'b0;
                end
                default: r.data_role = DR_UNKNOWN;
            endcase
        end
        if (int'(row_fill) + 1 > ROW_BYTES)
        begin
            row_fill    = 2'd1;
            r.byte_kind = BK_DATA_NEW_ROW;
        end
        else
        begin
            row_fill    = row_fill + 2'd1;
            r.byte_kind = BK_DATA_SAME;
        end
        return r;
    endfunction

    // Present one byte, hold it until the transfer, then queue its result.
    // Entered and left at a falling edge; tvalid stays high for a back-to-back byte.
    task automatic send_byte(input logic [7:0] b, input bit has_expect, input result_t want);
        int      gap;
        result_t pred;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        pred = decode_midi_byte(b);
        expected_results.push_back(has_expect ? want : pred);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_interjection();
        case ($urandom_range(0, 5))
            0:       return BYTE_CLOCK;
            1:       return BYTE_START;
            2:       return BYTE_CONTINUE;
            3:       return BYTE_STOP;
            4:       return BYTE_RESET;
            default: return BYTE_ACTIVE_SENSE;
        endcase
    endfunction

    // Lean towards the ends of the range so bend and song position hit them
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return {1'b0, 7'($urandom)};
        endcase
    endfunction

    task automatic send_data(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_byte(pick_interjection(), 1'b0, '0);
            send_byte(pick_data(), 1'b0, '0);
        end
    endtask

    task automatic send_message();
        int         sel;
        int         n;
        logic [7:0] st;
        if ($urandom_range(0, 15) == 0)
            no_idle = !no_idle;
        sel = $urandom_range(0, 11);
        if (sel <= 5)
        begin
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
            n  = (st[6:4] == 3'd4 || st[6:4] == 3'd5) ? 1 : 2;
            // leave the status out now and then to lean on running status
            if ($urandom_range(0, 3) != 0)
                send_byte(st, 1'b0, '0);
            repeat ($urandom_range(1, 3)) send_data(n);
        end
        else if (sel == 6)
        begin
            send_byte(BYTE_SONG_POS, 1'b0, '0);
            send_data(2);
        end
        else if (sel == 7)
        begin
            send_byte(BYTE_SONG_SEL, 1'b0, '0);
            send_data(1);
        end
        else if (sel == 8)
        begin
            send_byte(BYTE_SYSEX, 1'b0, '0);
            send_data($urandom_range(1, 4));
            send_byte(BYTE_EOX, 1'b0, '0);
        end
        else if (sel == 9)
            send_byte({4'hF, 4'($urandom)}, 1'b0, '0);
        else
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch at index %0d: %s expected %0d, got %0d",
                         want_res.byte_index, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with nothing expected: %h", m_tdata);
            end
            else
            begin
                want_res = expected_results.pop_front();
                got_res  = result_t'(m_tdata[75:0]);
                compare_field("byte_index", want_res.byte_index, got_res.byte_index);
                compare_field("byte_kind", want_res.byte_kind, got_res.byte_kind);
                compare_field("status_code", want_res.status_code, got_res.status_code);
                compare_field("channel_number", want_res.channel_number,
                              got_res.channel_number);
                compare_field("data_role", want_res.data_role, got_res.data_role);
                compare_field("note_pitch", want_res.note_pitch, got_res.note_pitch);
                compare_field("note_octave", want_res.note_octave, got_res.note_octave);
                compare_field("controller_lsb", want_res.controller_lsb,
                              got_res.controller_lsb);
                compare_field("bend_value", want_res.bend_value, got_res.bend_value);
                compare_field("song_measure", want_res.song_measure, got_res.song_measure);
                compare_field("song_beat", want_res.song_beat, got_res.song_beat);
                compare_field("song_clock", want_res.song_clock, got_res.song_clock);
                compare_field("padding", 0, m_tdata[79:76]);
            end
        end
    end

    // Stop a run in which no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : result_side
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        run_kind       = MK_UNKNOWN;
        second_pending = 1'b0;
        held_low       = 7'd0;
        byte_count     = 16'd0;
        row_fill       = 2'd0;
        sense_reported = 1'b0;

        // data before any status, row break, active sensing first and repeated
        dir_rows.push_back('{8'h00, 1'b1,
            fixed_result(16'd1, BK_DATA_SAME, SC_NONE, CH_NONE, DR_UNKNOWN)});
        dir_rows.push_back('{8'h7F, 1'b1,
            fixed_result(16'd2, BK_DATA_SAME, SC_NONE, CH_NONE, DR_UNKNOWN)});
        dir_rows.push_back('{8'h7F, 1'b1,
            fixed_result(16'd3, BK_DATA_NEW_ROW, SC_NONE, CH_NONE, DR_UNKNOWN)});
        dir_rows.push_back('{BYTE_ACTIVE_SENSE, 1'b1,
            fixed_result(16'd3, BK_SENSE_FIRST, SC_NONE, CH_NONE, DR_UNKNOWN)});
        dir_rows.push_back('{BYTE_ACTIVE_SENSE, 1'b1,
            fixed_result(16'd3, BK_SENSE_REPEAT, SC_NONE, CH_NONE, DR_UNKNOWN)});
        dir_rows.push_back('{8'h8F, 1'b1,
            fixed_result(16'd4, BK_STATUS, SC_NOTE_OFF, 5'd16, DR_UNKNOWN)});
        dir_rows.push_back('{8'h00, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, '0});
        // key pressure with a clock between note and value
        dir_rows.push_back('{8'hA0, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, '0});
        dir_rows.push_back('{BYTE_CLOCK, 1'b0, '0});
        dir_rows.push_back('{8'h40, 1'b0, '0});
        dir_rows.push_back('{8'hB3, 1'b0, '0});
        dir_rows.push_back('{8'h20, 1'b0, '0});
        // channel pressure: every data byte stands alone
        dir_rows.push_back('{8'hD9, 1'b0, '0});
        dir_rows.push_back('{8'h55, 1'b0, '0});
        dir_rows.push_back('{8'h66, 1'b0, '0});
        dir_rows.push_back('{8'hE0, 1'b1,
            fixed_result(16'd16, BK_STATUS, SC_PITCH_BEND, 5'd1, DR_UNKNOWN)});
        dir_rows.push_back('{8'h00, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b0, '0});
        dir_rows.push_back('{BYTE_SONG_POS, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, '0});
        dir_rows.push_back('{8'hF1, 1'b1,
            fixed_result(16'd22, BK_STATUS, SC_UNDEFINED, CH_NONE, DR_UNKNOWN)});
        dir_rows.push_back('{8'h00, 1'b1,
            fixed_result(16'd23, BK_DATA_SAME, SC_NONE, CH_NONE, DR_UNKNOWN)});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].midi_byte, dir_rows[i].has_expect, dir_rows[i].want);

        while (bytes_sent < 650)
            send_message();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/msd_pkg.sv
rtl/core/midi_stream_decoder_core.sv
verif/tb_top.sv
